### design/pcx_rle_image_decoder_assert.svh
// Assertion macros shared by the checker.
// Both sample on the rising edge of clk_i and are quiet while rst_ni is low.
`ifndef PCX_RLE_IMAGE_DECODER_ASSERT_SVH
`define PCX_RLE_IMAGE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define PCX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pcx_rle_pkg.sv
package pcx_rle_pkg;

  // Request codes on req_type.
  typedef enum logic [1:0] {
    ReqPalette = 2'd0,
    ReqCode    = 2'd1,
    ReqStart   = 2'd2
  } req_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgPlanar = 2'd2
  } cfg_e;

  localparam int unsigned DimW      = 13;
  localparam int unsigned PosW      = 12;
  localparam int unsigned PalDepth  = 256;
  localparam int unsigned PalAddrW  = 8;

  localparam logic [DimW-1:0] MaxDim  = 13'd4096;
  localparam logic [1:0]      RunMark = 2'b11;   // top bits of a run-count byte
  localparam logic [1:0]      PlaneLast    = 2'd2;
  localparam logic [1:0]      PlanePalette = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

### design/pcx_rle_image_decoder.sv
// PCX 8-bit RLE decoder. Palette write, start and run-count beats are taken while idle
// and do not stall the input. A value beat passes StRoom and StCheck for the room check,
// then emits one pixel per free output slot in StEmit; on overrun StCheck sends one error
// beat instead, once the output slot is free.
// Output beats are loaded only from StCheck and StEmit; palette reads use one sync RAM port.
// Async active-low reset resets control and config; the palette RAM is not cleared.
module pcx_rle_image_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,

  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,

  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  code_byte_i,
  input  logic [7:0]  palette_index_i,
  input  logic [7:0]  pal_red_i,
  input  logic [7:0]  pal_green_i,
  input  logic [7:0]  pal_blue_i,

  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] pixel_x_o,
  output logic [11:0] pixel_y_o,
  output logic [1:0]  plane_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        run_last_o,
  output logic        image_done_o,
  output logic        run_error_o
);

  localparam int unsigned DimW  = pcx_rle_pkg::DimW;
  localparam int unsigned ProdW = 2 * DimW;
  localparam int unsigned RoomW = ProdW + 1;

  typedef enum logic [1:0] {
    StIdle,   // takes input beats
    StRoom,   // rows-left product
    StCheck,  // overrun decision
    StEmit    // one pixel per free output slot
  } state_e;

  state_e state_q;

  // ---------------------------------------------------------------------------
  // Palette RAM: one write port (palette beats), one registered read port
  // (addressed by each code byte when it is accepted). Only one beat is taken
  // per cycle, so a write and a read never meet in the same cycle.
  // ---------------------------------------------------------------------------
  pcx_rle_pkg::rgb_t pal_mem [pcx_rle_pkg::PalDepth];
  pcx_rle_pkg::rgb_t pal_rd_q;

  logic in_accept;
  logic pal_wr_en;
  logic pal_rd_en;

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pal_wr_en  = in_accept && (req_type_i == pcx_rle_pkg::ReqPalette);
  assign pal_rd_en  = in_accept && (req_type_i == pcx_rle_pkg::ReqCode);

  always_ff @(posedge clk_i) begin
    if (pal_wr_en) begin
      pal_mem[palette_index_i] <= '{red: pal_red_i, green: pal_green_i, blue: pal_blue_i};
    end
    if (pal_rd_en) begin
      pal_rd_q <= pal_mem[code_byte_i];
    end
  end

  // ---------------------------------------------------------------------------
  // Config registers. Always ready; writes land only while idle by contract.
  // ---------------------------------------------------------------------------
  logic [DimW-1:0] width_q, height_q;
  logic            planar_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(1);
      height_q <= DimW'(1);
      planar_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pcx_rle_pkg::CfgWidth:  width_q  <= cfg_data_i;
        pcx_rle_pkg::CfgHeight: height_q <= cfg_data_i;
        pcx_rle_pkg::CfgPlanar: planar_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Saturate dimensions into 1..MaxDim.
  logic [DimW-1:0] dim_w, dim_h;

  always_comb begin
    dim_w = width_q;
    if (width_q == '0) begin
      dim_w = DimW'(1);
    end else if (width_q > pcx_rle_pkg::MaxDim) begin
      dim_w = pcx_rle_pkg::MaxDim;
    end
    dim_h = height_q;
    if (height_q == '0) begin
      dim_h = DimW'(1);
    end else if (height_q > pcx_rle_pkg::MaxDim) begin
      dim_h = pcx_rle_pkg::MaxDim;
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder state
  // ---------------------------------------------------------------------------
  logic            pending_q;
  logic [5:0]      run_len_q;
  logic [5:0]      cnt_q;       // pixels still to emit for this value
  logic [7:0]      value_q;
  logic [DimW-1:0] cur_x_q, cur_y_q;
  logic [1:0]      cur_plane_q;
  logic            error_q, done_q;
  logic            oob_q;
  logic [ProdW-1:0] prod_q;

  logic            out_valid_q;
  logic [11:0]     pixel_x_q, pixel_y_q;
  logic [1:0]      plane_q;
  logic [7:0]      red_q, green_q, blue_q;
  logic            last_q, img_done_q, err_q;

  logic            is_run_byte;
  logic [5:0]      value_count;
  logic [DimW-1:0] rows_left, x_room, x_inc, y_inc;
  logic [RoomW-1:0] room;
  logic            overrun;
  logic            x_wrap, row_wrap, fin;
  logic            out_free;

  always_comb begin
    is_run_byte = !pending_q && (code_byte_i[7:6] == pcx_rle_pkg::RunMark);
    value_count = pending_q ? run_len_q : 6'd1;

    rows_left = dim_h - cur_y_q - DimW'(1);
    x_room    = dim_w - cur_x_q;
    room      = planar_q ? RoomW'(x_room) : (RoomW'(prod_q) + RoomW'(x_room));
    overrun   = oob_q || (RoomW'(cnt_q) > room);

    x_inc    = cur_x_q + DimW'(1);
    y_inc    = cur_y_q + DimW'(1);
    x_wrap   = (x_inc >= dim_w);
    row_wrap = x_wrap && (!planar_q || (cur_plane_q == pcx_rle_pkg::PlaneLast));
    fin      = row_wrap && (y_inc >= dim_h);

    out_free = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pending_q   <= 1'b0;
      run_len_q   <= '0;
      cnt_q       <= '0;
      value_q     <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_plane_q <= '0;
      error_q     <= 1'b0;
      done_q      <= 1'b0;
      oob_q       <= 1'b0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      pixel_x_q   <= '0;
      pixel_y_q   <= '0;
      plane_q     <= '0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      last_q      <= 1'b0;
      img_done_q  <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      // drop the result once taken; loads below override
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_accept) begin
            case (req_type_i)
              pcx_rle_pkg::ReqStart: begin
                pending_q   <= 1'b0;
                run_len_q   <= '0;
                cur_x_q     <= '0;
                cur_y_q     <= '0;
                cur_plane_q <= '0;
                error_q     <= 1'b0;
                done_q      <= 1'b0;
              end
              pcx_rle_pkg::ReqCode: begin
                if (!error_q && !done_q) begin
                  if (is_run_byte) begin
                    pending_q <= 1'b1;
                    run_len_q <= code_byte_i[5:0];
                  end else begin
                    pending_q <= 1'b0;
                    run_len_q <= '0;
                    if (value_count != '0) begin
                      cnt_q   <= value_count;
                      value_q <= code_byte_i;
                      state_q <= StRoom;
                    end
                  end
                end
              end
              default: ;  // palette writes go to the RAM; code 3 is ignored
            endcase
          end
        end

        StRoom: begin
          oob_q   <= (cur_x_q >= dim_w) || (cur_y_q >= dim_h);
          prod_q  <= ProdW'(rows_left) * ProdW'(dim_w);
          state_q <= StCheck;
        end

        StCheck: begin
          if (!overrun) begin
            state_q <= StEmit;
          end else if (out_free) begin
            // single error beat at the current position
            out_valid_q <= 1'b1;
            pixel_x_q   <= cur_x_q[11:0];
            pixel_y_q   <= cur_y_q[11:0];
            plane_q     <= planar_q ? cur_plane_q : pcx_rle_pkg::PlanePalette;
            red_q       <= '0;
            green_q     <= '0;
            blue_q      <= '0;
            last_q      <= 1'b1;
            img_done_q  <= 1'b0;
            err_q       <= 1'b1;
            error_q     <= 1'b1;
            state_q     <= StIdle;
          end
        end

        StEmit: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            pixel_x_q   <= cur_x_q[11:0];
            pixel_y_q   <= cur_y_q[11:0];
            if (planar_q) begin
              plane_q <= cur_plane_q;
              red_q   <= value_q;
              green_q <= '0;
              blue_q  <= '0;
            end else begin
              plane_q <= pcx_rle_pkg::PlanePalette;
              red_q   <= pal_rd_q.red;
              green_q <= pal_rd_q.green;
              blue_q  <= pal_rd_q.blue;
            end
            last_q     <= (cnt_q == 6'd1);
            img_done_q <= fin;
            err_q      <= 1'b0;

            // advance position
            if (!x_wrap) begin
              cur_x_q <= x_inc;
            end else begin
              cur_x_q <= '0;
              if (!row_wrap) begin
                cur_plane_q <= cur_plane_q + 2'd1;
              end else begin
                cur_plane_q <= '0;
                cur_y_q     <= y_inc;
              end
            end
            if (fin) begin
              done_q <= 1'b1;
            end

            cnt_q <= cnt_q - 6'd1;
            if (cnt_q == 6'd1) begin
              state_q <= StIdle;
            end
          end
        end

        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pixel_x_q;
  assign pixel_y_o    = pixel_y_q;
  assign plane_o      = plane_q;
  assign out_red_o    = red_q;
  assign out_green_o  = green_q;
  assign out_blue_o   = blue_q;
  assign run_last_o   = last_q;
  assign image_done_o = img_done_q;
  assign run_error_o  = err_q;

endmodule

### design/pcx_rle_checker.sv
`include "pcx_rle_image_decoder_assert.svh"

module pcx_rle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] pixel_x_o,
  input logic [11:0] pixel_y_o,
  input logic [1:0]  plane_o,
  input logic [7:0]  out_red_o,
  input logic [7:0]  out_green_o,
  input logic [7:0]  out_blue_o,
  input logic        run_last_o,
  input logic        image_done_o,
  input logic        run_error_o
);

  logic hold;
  assign hold = out_valid_o && out_stall_i;

  `PCX_ASSERT_NEXT(a_out_valid_holds, hold, out_valid_o, "result beat dropped while stalled")
  `PCX_ASSERT_NEXT(a_out_payload_holds, hold, $stable({pixel_x_o, pixel_y_o, plane_o, out_red_o, out_green_o, out_blue_o, run_last_o, image_done_o, run_error_o}), "stalled result changed")
  `PCX_ASSERT_NOW(a_error_ends_run, out_valid_o && run_error_o, run_last_o && !image_done_o && out_red_o == 8'd0 && out_green_o == 8'd0 && out_blue_o == 8'd0, "overrun beat malformed")
  `PCX_ASSERT_NOW(a_done_ends_run, out_valid_o && image_done_o, run_last_o && !run_error_o, "image end not on last pixel of a run")

endmodule

bind pcx_rle_image_decoder pcx_rle_checker u_pcx_rle_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pixel_x_o    (pixel_x_o),
  .pixel_y_o    (pixel_y_o),
  .plane_o      (plane_o),
  .out_red_o    (out_red_o),
  .out_green_o  (out_green_o),
  .out_blue_o   (out_blue_o),
  .run_last_o   (run_last_o),
  .image_done_o (image_done_o),
  .run_error_o  (run_error_o)
);

### verif/pcx_rle_image_decoder_tb.sv
module pcx_rle_image_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DimW = pcx_rle_pkg::DimW;
  localparam int unsigned PosW = pcx_rle_pkg::PosW;

  // Request code 3 has no meaning; the block must drop such a beat.
  localparam logic [1:0] ReqUnused = 2'd3;

  localparam int NumRows      = 29;   // directed table rows (config writes included)
  localparam int RandomItems  = 390;  // beats that do real work in the random part
  localparam int SettleCycles = 16;   // idle time in drain() after the last owed result

  // One input beat, as driven on the payload ports.
  typedef struct packed {
    logic [1:0] req;
    logic [7:0] code;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } beat_t;

  // One result beat, field for field as the output ports carry it.
  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic [1:0]      plane;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic            last;
    logic            done;
    logic            err;
  } pix_t;

  // Directed table row: either a register write or a beat. A typed row carries
  // the single result that it must cause, written out by hand.
  typedef struct {
    bit                 is_cfg;
    pcx_rle_pkg::cfg_e  reg_idx;
    logic [DimW-1:0]    reg_val;
    beat_t              bt;
    bit                 typed;
    pix_t               want;
  } row_t;

  // ---------------------------------------------------------------------------
  // DUT ports
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [7:0]  code_byte_i;
  logic [7:0]  palette_index_i;
  logic [7:0]  pal_red_i;
  logic [7:0]  pal_green_i;
  logic [7:0]  pal_blue_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [11:0] pixel_x_o;
  logic [11:0] pixel_y_o;
  logic [1:0]  plane_o;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;
  logic        run_last_o;
  logic        image_done_o;
  logic        run_error_o;

  pcx_rle_image_decoder u_dut (.*);

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Decoder state as the testbench sees it. Updated at the edge where a beat
  // or a register write is accepted, so it always matches what the block has
  // taken in so far.
  // ---------------------------------------------------------------------------
  logic [DimW-1:0]   dim_w_reg, dim_h_reg;   // raw register contents, clamped on use
  bit                planar_mode;
  pcx_rle_pkg::rgb_t pal_rgb [pcx_rle_pkg::PalDepth];
  bit                pal_set [pcx_rle_pkg::PalDepth];  // entries written; only these are read
  bit                run_pend;
  logic [5:0]        run_len;
  logic [DimW-1:0]   cur_x, cur_y;           // one bit wider than the ports, for the wrap test
  logic [1:0]        cur_plane;
  bit                img_err, img_done;

  pix_t pixels_due [$];                      // results still owed by the block, oldest first

  int burst_left   = 0;
  bit quiet        = 1'b0;                   // no sender gaps in this phase
  int items_fed    = 0;
  int phases       = 0;
  int overruns_due = 0;
  int pixels_seen  = 0;
  int fail_count   = 0;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    if (v == '0) return DimW'(1);
    if (v > pcx_rle_pkg::MaxDim) return pcx_rle_pkg::MaxDim;
    return v;
  endfunction

  function automatic void clear_image();
    run_pend  = 1'b0;
    run_len   = '0;
    cur_x     = '0;
    cur_y     = '0;
    cur_plane = '0;
    img_err   = 1'b0;
    img_done  = 1'b0;
  endfunction

  // Works out the results of one accepted beat and queues them.
  task automatic decode_beat(input beat_t bt);
    logic [DimW-1:0]   w, h;
    longint            room;
    int unsigned       n;
    bit                row_end;
    pcx_rle_pkg::rgb_t c;
    pix_t              p;
    case (bt.req)
      pcx_rle_pkg::ReqPalette: begin
        pal_rgb[bt.idx] = {bt.red, bt.green, bt.blue};
        pal_set[bt.idx] = 1'b1;
      end
      pcx_rle_pkg::ReqStart: clear_image();
      pcx_rle_pkg::ReqCode: begin
        if (img_err || img_done) return;
        // run-count byte: only counts when no run is already waiting for its value
        if (!run_pend && bt.code[7:6] == pcx_rle_pkg::RunMark) begin
          run_pend = 1'b1;
          run_len  = bt.code[5:0];
          return;
        end
        n        = run_pend ? 32'(run_len) : 32'd1;
        run_pend = 1'b0;
        run_len  = '0;
        if (n == 0) return;

        w = clamp_dim(dim_w_reg);
        h = clamp_dim(dim_h_reg);
        if (cur_x >= w || cur_y >= h) room = 0;
        else if (planar_mode) room = longint'(w) - longint'(cur_x);
        else room = (longint'(h) - longint'(cur_y) - 1) * longint'(w)
                    + (longint'(w) - longint'(cur_x));

        // overrun: one error beat at the current spot, nothing drawn
        if (longint'(n) > room) begin
          img_err = 1'b1;
          overruns_due++;
          p = '{cur_x[PosW-1:0], cur_y[PosW-1:0],
                planar_mode ? cur_plane : pcx_rle_pkg::PlanePalette,
                8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1};
          pixels_due.push_back(p);
          return;
        end

        for (int unsigned k = 0; k < n; k++) begin
          p.x    = cur_x[PosW-1:0];
          p.y    = cur_y[PosW-1:0];
          p.last = (k == n - 1);
          p.done = 1'b0;
          p.err  = 1'b0;
          if (planar_mode) begin
            p.plane = cur_plane;
            p.red   = bt.code;
            p.green = 8'h00;
            p.blue  = 8'h00;
          end else begin
            c       = pal_rgb[bt.code];
            p.plane = pcx_rle_pkg::PlanePalette;
            p.red   = c.red;
            p.green = c.green;
            p.blue  = c.blue;
          end
          cur_x++;
          if (cur_x >= w) begin
            cur_x   = '0;
            row_end = 1'b1;
            // planar rows hold three lines; move to the next plane first
            if (planar_mode) begin
              if (cur_plane == pcx_rle_pkg::PlaneLast) cur_plane = '0;
              else begin
                cur_plane++;
                row_end = 1'b0;
              end
            end
            if (row_end) begin
              cur_y++;
              if (cur_y >= h) begin
                p.done   = 1'b1;
                img_done = 1'b1;
              end
            end
          end
          pixels_due.push_back(p);
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report(input string what, input longint got, input longint want);
    fail_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin : result_check
    pix_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {pixel_x_o, pixel_y_o, plane_o, out_red_o, out_green_o, out_blue_o,
             run_last_o, image_done_o, run_error_o};
      pixels_seen++;
      if (pixels_due.size() == 0) report("result beat with none owed", 64'(got), 64'd0);
      else begin
        want = pixels_due.pop_front();
        if (got.x !== want.x)         report("pixel_x", 64'(got.x), 64'(want.x));
        if (got.y !== want.y)         report("pixel_y", 64'(got.y), 64'(want.y));
        if (got.plane !== want.plane) report("plane", 64'(got.plane), 64'(want.plane));
        if (got.red !== want.red)     report("out_red", 64'(got.red), 64'(want.red));
        if (got.green !== want.green) report("out_green", 64'(got.green), 64'(want.green));
        if (got.blue !== want.blue)   report("out_blue", 64'(got.blue), 64'(want.blue));
        if (got.last !== want.last)   report("run_last", 64'(got.last), 64'(want.last));
        if (got.done !== want.done)   report("image_done", 64'(got.done), 64'(want.done));
        if (got.err !== want.err)     report("run_error", 64'(got.err), 64'(want.err));
      end
    end
  end

  // Receiver back-pressure: stretches of no stall, coin-flip stall, a fixed
  // one-in-three pattern and heavy stall, each for a stretch of random length.
  int rx_mode = 0;
  int rx_left = 0;

  always @(posedge clk_i) begin : rx_pattern
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    case (rx_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= 1'($urandom_range(0, 1));
      2:       out_stall_i <= (rx_left % 3 == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Sends one beat, with the sender idling between bursts. A typed row swaps
  // what the predictor queued for the hand-written result.
  task automatic send_beat(input beat_t bt, input bit typed, input pix_t want);
    int gap;
    int before_n;
    cfg_valid_i <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = quiet ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    req_type_i      <= bt.req;
    code_byte_i     <= bt.code;
    palette_index_i <= bt.idx;
    pal_red_i       <= bt.red;
    pal_green_i     <= bt.green;
    pal_blue_i      <= bt.blue;
    do @(posedge clk_i); while (in_stall_o);
    // beats the block drops do not count toward RandomItems
    if (!(bt.req == ReqUnused ||
          (bt.req == pcx_rle_pkg::ReqCode && (img_err || img_done)))) items_fed++;
    before_n = pixels_due.size();
    decode_beat(bt);
    if (typed) begin
      while (pixels_due.size() > before_n) void'(pixels_due.pop_back());
      pixels_due.push_back(want);
    end
  endtask

  // Register write. Valid is left high so back-to-back writes need no gap;
  // the next beat or drain lowers it.
  task automatic write_reg(input pcx_rle_pkg::cfg_e idx, input logic [DimW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pcx_rle_pkg::CfgWidth:  dim_w_reg = val;
      pcx_rle_pkg::CfgHeight: dim_h_reg = val;
      default:                planar_mode = val[0];
    endcase
  endtask

  // Stop sending, let every owed result come out, then give beats that cause
  // no result (run counts, empty runs) time to clear the pipe.
  task automatic drain();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    burst_left  = 0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic beat_t make_beat(logic [1:0] req, logic [7:0] code);
    beat_t bt;
    bt.req   = req;
    bt.code  = code;
    bt.idx   = 8'($urandom);
    bt.red   = 8'($urandom);
    bt.green = 8'($urandom);
    bt.blue  = 8'($urandom);
    return bt;
  endfunction

  // Value byte for the stream. Literals must stay clear of the run mark; in
  // palette mode only entries already written may be looked up.
  function automatic logic [7:0] pick_value(bit literal);
    logic [7:0] v;
    for (int t = 0; t < 64; t++) begin
      v = literal ? 8'($urandom_range(0, 8'hBF)) : 8'($urandom);
      if (planar_mode || pal_set[v]) return v;
    end
    return 8'h00;   // written by the directed part
  endfunction

  function automatic logic [DimW-1:0] pick_dim(int unsigned small_max);
    case ($urandom_range(0, 19))
      0:       return DimW'($urandom_range(0, 8191));
      1:       return pcx_rle_pkg::MaxDim;
      2:       return '0;
      default: return DimW'($urandom_range(1, small_max));
    endcase
  endfunction

  // Directed table helpers.
  function automatic pix_t pix(logic [PosW-1:0] x, logic [PosW-1:0] y, logic [1:0] pl,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b,
                               logic last, logic done, logic err);
    return '{x, y, pl, r, g, b, last, done, err};
  endfunction

  function automatic row_t beat_row(logic [1:0] req, logic [7:0] code);
    row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = pcx_rle_pkg::CfgWidth;
    r.reg_val = '0;
    r.bt      = make_beat(req, code);
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic row_t typed_row(logic [7:0] code, pix_t want);
    row_t r;
    r       = beat_row(pcx_rle_pkg::ReqCode, code);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t pal_row(logic [7:0] idx, logic [7:0] red, logic [7:0] green,
                                   logic [7:0] blue);
    row_t r;
    r          = beat_row(pcx_rle_pkg::ReqPalette, 8'h00);
    r.bt.idx   = idx;
    r.bt.red   = red;
    r.bt.green = green;
    r.bt.blue  = blue;
    return r;
  endfunction

  function automatic row_t cfg_row(pcx_rle_pkg::cfg_e idx, logic [DimW-1:0] val);
    row_t r;
    r         = beat_row(ReqUnused, 8'h00);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t plan [NumRows];
    int   phase_len, made, len;

    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= pcx_rle_pkg::CfgWidth;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    req_type_i      <= pcx_rle_pkg::ReqPalette;
    code_byte_i     <= '0;
    palette_index_i <= '0;
    pal_red_i       <= '0;
    pal_green_i     <= '0;
    pal_blue_i      <= '0;

    // state after reset: 1x1 image, palette mode, nothing written
    dim_w_reg   = DimW'(1);
    dim_h_reg   = DimW'(1);
    planar_mode = 1'b0;
    pal_set     = '{default: 1'b0};
    clear_image();

    plan = '{
      // reset size is 1x1 in palette mode: one literal fills the image
      pal_row(8'hFF, 8'hFF, 8'hFF, 8'hFF),
      pal_row(8'h00, 8'h00, 8'h80, 8'h7F),
      typed_row(8'h00, pix(12'd0, 12'd0, pcx_rle_pkg::PlanePalette,
                           8'h00, 8'h80, 8'h7F, 1'b1, 1'b1, 1'b0)),
      beat_row(pcx_rle_pkg::ReqCode, 8'h00),    // dropped, image complete
      beat_row(ReqUnused, 8'h5A),               // unused request code
      beat_row(pcx_rle_pkg::ReqStart, 8'h00),
      beat_row(pcx_rle_pkg::ReqCode, 8'hC1),    // run of one ...
      typed_row(8'hFF, pix(12'd0, 12'd0, pcx_rle_pkg::PlanePalette,
                           8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0)),
      beat_row(pcx_rle_pkg::ReqStart, 8'h00),
      beat_row(pcx_rle_pkg::ReqCode, 8'hC2),    // run of two into a one-pixel image
      typed_row(8'h00, pix(12'd0, 12'd0, pcx_rle_pkg::PlanePalette,
                           8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1)),
      beat_row(pcx_rle_pkg::ReqCode, 8'h05),    // dropped, error is sticky
      beat_row(pcx_rle_pkg::ReqStart, 8'h00),
      // planar, width register above range clamps to the largest size
      cfg_row(pcx_rle_pkg::CfgWidth, 13'h1FFF),
      cfg_row(pcx_rle_pkg::CfgHeight, 13'd2),
      cfg_row(pcx_rle_pkg::CfgPlanar, 13'd1),
      beat_row(pcx_rle_pkg::ReqCode, 8'hC0),    // empty run: count 0 ...
      beat_row(pcx_rle_pkg::ReqCode, 8'hAB),    // ... and its value, nothing drawn
      beat_row(pcx_rle_pkg::ReqCode, 8'hFF),    // longest run, 63 ...
      beat_row(pcx_rle_pkg::ReqCode, 8'hBF),    // ... of the largest literal
      typed_row(8'hBF, pix(12'd63, 12'd0, 2'd0, 8'hBF, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0)),
      // width shrinks under the current position: the next pixel overruns
      cfg_row(pcx_rle_pkg::CfgWidth, 13'd0),
      typed_row(8'h10, pix(12'd64, 12'd0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1)),
      beat_row(pcx_rle_pkg::ReqStart, 8'h00),
      // 1x1 planar: three plane beats, done on the blue one
      cfg_row(pcx_rle_pkg::CfgHeight, 13'd0),
      beat_row(pcx_rle_pkg::ReqCode, 8'h11),
      beat_row(pcx_rle_pkg::ReqCode, 8'h22),
      beat_row(pcx_rle_pkg::ReqCode, 8'h33),
      beat_row(pcx_rle_pkg::ReqCode, 8'h44)     // dropped, image complete
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_beat(plan[i].bt, plan[i].typed, plan[i].want);
      end
    end

    // Random part: one image phase at a time. Each phase starts from an idle
    // block (every owed result delivered), may retune the registers, and then
    // feeds a well-formed stream of runs and literals with some noise mixed in.
    items_fed = 0;
    while (items_fed < RandomItems) begin
      phases++;
      drain();
      quiet = ($urandom_range(0, 3) == 0);

      if (phases == 1 || $urandom_range(0, 9) < 7)
        write_reg(pcx_rle_pkg::CfgWidth, pick_dim(10));
      if (phases == 1 || $urandom_range(0, 9) < 7)
        write_reg(pcx_rle_pkg::CfgHeight, pick_dim(5));
      if (phases == 1 || $urandom_range(0, 9) < 5)
        write_reg(pcx_rle_pkg::CfgPlanar, DimW'($urandom_range(0, 1)));

      // most phases start a fresh image; the rest carry on mid-image
      if ($urandom_range(0, 6) != 0)
        send_beat(make_beat(pcx_rle_pkg::ReqStart, 8'($urandom)), 1'b0, '0);

      if (!planar_mode)
        repeat ($urandom_range(2, 8))
          send_beat(make_beat(pcx_rle_pkg::ReqPalette, 8'($urandom)), 1'b0, '0);

      phase_len = $urandom_range(6, 40);
      made      = 0;
      while (made < phase_len && !img_err && !img_done) begin
        case ($urandom_range(0, 19))
          0: send_beat(make_beat(ReqUnused, 8'($urandom)), 1'b0, '0);
          1: send_beat(make_beat(pcx_rle_pkg::ReqPalette, 8'($urandom)), 1'b0, '0);
          2: send_beat(make_beat(pcx_rle_pkg::ReqStart, 8'($urandom)), 1'b0, '0);
          3, 4, 5, 6, 7, 8, 9: begin
            case ($urandom_range(0, 9))
              0:       len = 0;
              1, 2:    len = $urandom_range(7, 63);
              default: len = $urandom_range(1, 6);
            endcase
            send_beat(make_beat(pcx_rle_pkg::ReqCode, {pcx_rle_pkg::RunMark, 6'(len)}),
                      1'b0, '0);
            send_beat(make_beat(pcx_rle_pkg::ReqCode, pick_value(1'b0)), 1'b0, '0);
          end
          default: send_beat(make_beat(pcx_rle_pkg::ReqCode, pick_value(1'b1)), 1'b0, '0);
        endcase
        made++;
      end

      // now and then a byte after the image has ended or failed
      if ((img_err || img_done) && $urandom_range(0, 2) == 0)
        send_beat(make_beat(pcx_rle_pkg::ReqCode, 8'($urandom)), 1'b0, '0);
    end

    drain();

    $display("Covered %0d working beats over %0d image phases, palette and planar modes.",
             items_fed, phases);
    $display("Checked %0d result beats, %0d overruns expected, %0d mismatches.",
             pixels_seen, overruns_due, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run (every beat a 63-pixel run
  // under heavy receiver stall).
  initial begin : watchdog
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
